// File: rtl/rbp_pkg.sv
// Shared types and constants for the RGB to BGR222 palette builder.
package rbp_pkg;

    localparam int CODE_W    = 6;
    localparam int NUM_CODES = 64;
    localparam int COUNT_W   = 7;
    localparam int SLOT_W    = 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       first_pixel;
    } pixel_t;

    typedef struct packed {
        logic [CODE_W-1:0]  color_code;
        logic               is_new;
        logic [SLOT_W-1:0]  slot_index;
        logic               palette_overflow;
        logic [COUNT_W-1:0] unique_count;
        logic               too_many_colors;
    } result_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOOKUP
    } state_t;

endpackage

// File: rtl/rbp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module rbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/rgb_to_bgr222_palette_builder.sv
// Top level of the RGB888 to BGR222 palette builder.
//
// Usage:
//   A pixel request enters on pixel/pixel_valid/pixel_ready and one result
//   request leaves on result/result_valid/result_ready for every pixel.
//   The color code keeps the top two bits of each channel as BBGGRR.
//   A pixel with first_pixel set starts a new image: the presence map and
//   the distinct count are cleared before that pixel is looked up.
//   A code enters the palette when it is first seen and a slot is free;
//   slots fill in order, so the slot given equals the distinct count
//   before the pixel. A per-code RAM holds whether that code got a slot.
// Timing:
//   A pixel passes from the lookup state into the output register. No
//   new pixel is taken while one is in the lookup state, which uses the
//   registered read of the per-code RAM. A pixel may be accepted while
//   an earlier result still waits in the output register.
// Reset and stalls:
//   Reset empties the presence map, the count and the output register.
//   When the receiver stalls, the looked-up pixel waits in the lookup
//   stage, and no new pixel is taken until its result enters the output register.
module rgb_to_bgr222_palette_builder
    import rbp_pkg::*;
#(
    parameter int PALETTE_SLOTS = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pixel_valid,
    output logic    pixel_ready,
    input  pixel_t  pixel,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam logic [COUNT_W-1:0] SLOTS_LIMIT = COUNT_W'(PALETTE_SLOTS);

    state_t               state_reg, state_next;
    logic [NUM_CODES-1:0] seen_reg, seen_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic                 result_valid_reg, result_valid_next;
    result_t              result_reg, result_next;

    logic              pixel_fire;
    logic              out_free;
    logic              finish;
    logic [CODE_W-1:0] pixel_code;
    logic              ram_in_pal;
    logic              seen_hit;
    logic              room_left;
    logic              write_pal;

    // Color code of the incoming pixel: blue, green, red top bits.
    assign pixel_code = {pixel.blue[7:6], pixel.green[7:6], pixel.red[7:6]};

    // Per-code RAM: one bit telling whether the code was given a slot when it
    // was first seen. Entries are meaningful only where the seen bit is set.
    rbp_ram #(
        .WIDTH (1),
        .DEPTH (NUM_CODES)
    ) u_pal_ram (
        .clk   (clk),
        .we    (finish & ~seen_hit),
        .waddr (code_reg),
        .wdata (write_pal),
        .re    (pixel_fire),
        .raddr (pixel_code),
        .rdata (ram_in_pal)
    );

    assign out_free  = ~result_valid_reg | result_ready;
    assign seen_hit  = seen_reg[code_reg];
    assign room_left = (count_reg < SLOTS_LIMIT);
    assign write_pal = room_left;

    always_comb
    begin
        state_next        = state_reg;
        seen_next         = seen_reg;
        count_next        = count_reg;
        code_next         = code_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg & ~result_ready;
        pixel_ready       = 1'b0;
        pixel_fire        = 1'b0;
        finish            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    pixel_fire = 1'b1;
                    code_next  = pixel_code;
                    state_next = S_LOOKUP;
                    // A new image forgets every code seen so far.
                    if (pixel.first_pixel)
                    begin
                        seen_next  = '0;
                        count_next = '0;
                    end
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    finish                   = 1'b1;
                    state_next               = S_IDLE;
                    result_valid_next        = 1'b1;
                    result_next.color_code   = code_reg;
                    result_next.is_new       = 1'b0;
                    result_next.slot_index   = '0;
                    result_next.palette_overflow = 1'b0;
                    if (seen_hit)
                    begin
                        // Known code: it is in the palette only if it got a slot.
                        result_next.palette_overflow = ~ram_in_pal;
                        result_next.unique_count     = count_reg;
                        result_next.too_many_colors  = (count_reg > SLOTS_LIMIT);
                    end
                    else
                    begin
                        // First sighting: the slot number is the count so far, if a slot is free.
                        seen_next[code_reg]          = 1'b1;
                        count_next                   = count_reg + 1'b1;
                        result_next.is_new           = room_left;
                        result_next.slot_index       = room_left ? count_reg[SLOT_W-1:0] : '0;
                        result_next.palette_overflow = ~room_left;
                        result_next.unique_count     = count_reg + 1'b1;
                        result_next.too_many_colors  = ((count_reg + 1'b1) > SLOTS_LIMIT);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            seen_reg         <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            seen_reg         <= seen_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // The distinct count always matches the number of set presence bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(seen_reg) == 32'(count_reg))
        else $error("distinct count disagrees with presence map");

    // A newly added code can never also be reported as an overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_new |-> !result.palette_overflow)
        else $error("new code flagged as overflow");

    // An accepted pixel always moves into the lookup stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> state_reg == S_LOOKUP)
        else $error("accepted pixel not looked up");

    // A finished lookup always leaves a valid result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOKUP && state_next == S_IDLE |=> result_valid)
        else $error("lookup finished without a result");
`endif

endmodule

// File: verif/rgb_to_bgr222_palette_builder_tb.sv
// Testbench for the RGB888 to BGR222 palette builder: directed and random images, all predicted.
module rgb_to_bgr222_palette_builder_tb;
    import rbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAL_SLOTS  = 16;
    // Cycles with no request moving on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 1000;
    // Length of the final quiet period, in which a stray result would show.
    localparam int TAIL_CYCLES = 10;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    pixel_valid = 1'b0;
    logic    pixel_ready;
    pixel_t  pixel = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    // Image state of the predictor, at the widths the block keeps.
    logic [5:0] pal_codes [PAL_SLOTS];
    logic [4:0] pal_fill = '0;
    logic [63:0] code_seen = '0;
    logic [6:0] distinct_total = '0;

    result_t    pending_results [$];
    logic [5:0] color_pool [$];
    int         error_count = 0;
    int         pixels_sent = 0;
    int         idle_cycles = 0;
    int         stall_left = 0;
    // While set, the sender leaves gaps and the receiver stalls in short bursts.
    bit         idle_on = 1'b1;

    rgb_to_bgr222_palette_builder #(
        .PALETTE_SLOTS(PAL_SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .pixel(pixel),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always #5 clk = ~clk;

    // Works out the result of one pixel and advances the predicted image state.
    // A first pixel wipes the image before its own lookup, so its code always
    // lands in slot 0.
    function automatic result_t predict_pixel(pixel_t px);
        result_t    r;
        logic [5:0] code;
        bit         hit;
        if (px.first_pixel)
        begin
            pal_fill       = '0;
            code_seen      = '0;
            distinct_total = '0;
        end
        code = {px.blue[7:6], px.green[7:6], px.red[7:6]};
        hit  = 1'b0;
        if (!code_seen[code])
        begin
            code_seen[code] = 1'b1;
            if (distinct_total < 64)
                distinct_total = 7'(distinct_total + 1);
        end
        // Only filled slots are compared, so an unwritten entry is never read.
        for (int i = 0; i < PAL_SLOTS; i++)
        begin
            if (i < pal_fill && pal_codes[i] == code)
                hit = 1'b1;
        end
        r = '0;
        r.color_code = code;
        if (!hit)
        begin
            if (pal_fill < PAL_SLOTS)
            begin
                pal_codes[pal_fill[3:0]] = code;
                r.is_new     = 1'b1;
                r.slot_index = pal_fill[3:0];
                pal_fill     = 5'(pal_fill + 1);
            end
            else
            begin
                // A code refused while the palette is full stays out until the image
                // restarts, so every later pixel of it in that image overflows again.
                r.palette_overflow = 1'b1;
            end
        end
        r.unique_count    = distinct_total;
        r.too_many_colors = (distinct_total > PAL_SLOTS);
        return r;
    endfunction

    // Sends one pixel request. Any idle gap comes before the request is raised,
    // so valid is never dropped and raised in the same step. On return the
    // request has been taken and valid is still high; the caller either sends
    // the next pixel at once or lowers valid through wait_results_drained.
    task automatic send_pixel(pixel_t px);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel       <= px;
        pixel_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pixel_ready);
        pending_results.push_back(predict_pixel(px));
        pixels_sent++;
    endtask

    // Sends a pixel of the given code with random bits below the top two of each
    // channel, which the block must ignore.
    task automatic send_code(logic [5:0] code, bit first);
        pixel_t px;
        px.red         = 8'($urandom());
        px.green       = 8'($urandom());
        px.blue        = 8'($urandom());
        px.red[7:6]    = code[1:0];
        px.green[7:6]  = code[3:2];
        px.blue[7:6]   = code[5:4];
        px.first_pixel = first;
        send_pixel(px);
    endtask

    // Lowers valid and holds the sender back until every expected result is in.
    task automatic wait_results_drained();
        pixel_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Fills the color pool with n distinct codes in random order.
    task automatic build_pool(int n);
        logic [5:0] all_codes [64];
        logic [5:0] tmp;
        int         j;
        for (int i = 0; i < 64; i++)
            all_codes[i] = 6'(i);
        for (int i = 63; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = all_codes[i];
            all_codes[i] = all_codes[j];
            all_codes[j] = tmp;
        end
        color_pool.delete();
        for (int i = 0; i < n; i++)
            color_pool.push_back(all_codes[i]);
    endtask

    // Sends an image drawn from the pool. Now and then a stray first-pixel flag
    // lands in the middle, restarting the image there.
    task automatic send_image(int len, bit flagged);
        bit first;
        for (int i = 0; i < len; i++)
        begin
            if (i == 0)
                first = flagged;
            else
                first = ($urandom_range(0, 49) == 0);
            send_code(color_pool[$urandom_range(0, color_pool.size() - 1)], first);
        end
    endtask

    // Picks a pool size: mostly within the palette, sometimes just past it,
    // and now and then far beyond it.
    function automatic int pick_pool_size();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom_range(1, PAL_SLOTS);
        else if (sel < 9)
            return $urandom_range(PAL_SLOTS + 1, PAL_SLOTS + 8);
        else
            return $urandom_range(PAL_SLOTS + 9, 64);
    endfunction

    // Extreme channel values, black, ignored low bits, a full palette, overflow
    // on a new code, the same refused code again, and a restart of the image.
    task automatic test_directed();
        pixel_t px;
        px = '{red: 8'h00, green: 8'h00, blue: 8'h00, first_pixel: 1'b1};
        send_pixel(px);
        px = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF, first_pixel: 1'b0};
        send_pixel(px);
        // Low bits all set, still black: already in the palette.
        px = '{red: 8'h3F, green: 8'h3F, blue: 8'h3F, first_pixel: 1'b0};
        send_pixel(px);
        px = '{red: 8'hC0, green: 8'h00, blue: 8'h00, first_pixel: 1'b0};
        send_pixel(px);
        px = '{red: 8'h00, green: 8'hC0, blue: 8'h00, first_pixel: 1'b0};
        send_pixel(px);
        px = '{red: 8'h00, green: 8'h00, blue: 8'hC0, first_pixel: 1'b0};
        send_pixel(px);
        // Eleven more distinct codes fill all sixteen slots.
        for (int i = 1; i <= 11; i++)
            send_code(6'(i * 5), 1'b0);
        // A new code with no free slot, then the same code once more.
        send_code(6'd60, 1'b0);
        send_code(6'd60, 1'b0);
        send_code(6'd5, 1'b0);
        // The refused code starts a fresh image and takes slot 0.
        send_code(6'd60, 1'b1);
        wait_results_drained();
    endtask

    // Many images of random size and color variety, most with gaps and stalls.
    // Some images carry no first-pixel flag and pile onto the one before.
    task automatic test_random_images(int target);
        int image_no;
        image_no = 0;
        while (pixels_sent < target)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            build_pool(pick_pool_size());
            if ($urandom_range(0, 7) == 0)
                send_image($urandom_range(60, 120), ($urandom_range(0, 9) != 0));
            else
                send_image($urandom_range(1, 40), ($urandom_range(0, 9) != 0));
            image_no++;
            // Every so often the sender holds off until the block is empty.
            if (image_no % 8 == 0)
                wait_results_drained();
        end
        wait_results_drained();
    endtask

    // One image holding every code, so the distinct count reaches its ceiling,
    // followed by repeats that must not move it.
    task automatic test_all_codes();
        idle_on = 1'b1;
        build_pool(64);
        for (int i = 0; i < 64; i++)
            send_code(color_pool[i], (i == 0));
        for (int i = 0; i < 64; i++)
            send_code(color_pool[$urandom_range(0, 63)], 1'b0);
        wait_results_drained();
    endtask

    // Final stretch with no gaps and no stalls, requests back to back.
    task automatic test_back_to_back(int count);
        int start;
        idle_on = 1'b0;
        start = pixels_sent;
        while (pixels_sent - start < count)
        begin
            build_pool(pick_pool_size());
            send_image($urandom_range(10, 50), 1'b1);
        end
        wait_results_drained();
    endtask

    task automatic check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            error_count++;
        end
    endtask

    // Receiver: ready most of the time, stalling in bursts of random length while idling is on.
    always @(posedge clk)
    begin
        if (!idle_on)
            result_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= $urandom_range(0, 4);
        end
        else
            result_ready <= 1'b1;
    end

    // Each result request taken is matched against the oldest prediction.
    always @(posedge clk)
    begin
        result_t exp;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no pending pixel, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                exp = pending_results.pop_front();
                check_field("color_code", 32'(exp.color_code), 32'(result.color_code));
                check_field("is_new", 32'(exp.is_new), 32'(result.is_new));
                check_field("slot_index", 32'(exp.slot_index), 32'(result.slot_index));
                check_field("palette_overflow", 32'(exp.palette_overflow),
                            32'(result.palette_overflow));
                check_field("unique_count", 32'(exp.unique_count),
                            32'(result.unique_count));
                check_field("too_many_colors", 32'(exp.too_many_colors),
                            32'(result.too_many_colors));
            end
        end
    end

    // Watchdog: ends the run if no request moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_images(1500);
        test_all_codes();
        test_back_to_back(200);

        // Nothing is pending now; give the block a short while to show any
        // stray result before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
